FILE: src/assert_macros.svh
// Assertion helper macros for the planar odometry integrator RTL.
// Included by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define POI_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define POI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/poi_pkg.sv
// Shared types, constants and tables for the planar odometry integrator.
// No dependencies; imported by poi_mul, planar_odometry_integrator_top and the testbench.
package poi_pkg;

    localparam int SPD_W      = 16;
    localparam int POS_W      = 32;
    localparam int HDG_W      = 16;
    localparam int ANG_W      = 32;
    localparam int PER_W      = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam int CORDIC_STEPS = 28;
    localparam int CNT_W        = 5;

    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 18;

    // 1/K in Q1.30
    localparam logic [ANG_W-1:0] CORDIC_INV_GAIN = 32'd652032874;
    // 8/pi in Q2.30, split in halves for the 33x18 multiplier
    localparam logic [15:0] RAD2BAM_HI = 16'hA2F9;
    localparam logic [15:0] RAD2BAM_LO = 16'h836E;

    localparam logic [PER_W-1:0] TICK_PERIOD_RST = 16'd1311;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRATE_EN = 4'd1;

    typedef struct packed {
        logic signed [SPD_W-1:0] fwd_speed;
        logic signed [SPD_W-1:0] side_speed;
        logic signed [SPD_W-1:0] turn_rate;
    } cmd_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pose_x;
        logic signed [POS_W-1:0] pose_y;
        logic [HDG_W-1:0]        pose_heading;
    } pose_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ROT,
        ST_FIX,
        ST_M0,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_M6,
        ST_M7,
        ST_M8,
        ST_M9,
        ST_M10,
        ST_M11,
        ST_M12,
        ST_RND,
        ST_UPD,
        ST_OUT
    } poi_state_t;

    // arctan(2^-i) as a 32-bit binary angle
    function automatic logic [ANG_W-1:0] atan_bam(input logic [CNT_W-1:0] i);
        logic [ANG_W-1:0] r;
        unique case (i)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2FA;
            5'd15:   r = 32'h0000517D;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A30;
            5'd19:   r = 32'h00000518;
            5'd20:   r = 32'h0000028C;
            5'd21:   r = 32'h00000146;
            5'd22:   r = 32'h000000A3;
            5'd23:   r = 32'h00000051;
            5'd24:   r = 32'h00000029;
            5'd25:   r = 32'h00000014;
            5'd26:   r = 32'h0000000A;
            5'd27:   r = 32'h00000005;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: src/poi_mul.sv
// Shared signed multiplier with registered product.
// Depends on poi_pkg for default operand widths.
module poi_mul
    import poi_pkg::*;
#(
    parameter int A_W = MUL_A_W,
    parameter int B_W = MUL_B_W
)
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [A_W-1:0]     a,
    input  logic signed [B_W-1:0]     b,
    output logic signed [A_W+B_W-1:0] prod
);

    logic signed [A_W+B_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

FILE: src/planar_odometry_integrator_top.sv
// Planar dead-reckoning odometry integrator, top level.
// Depends on poi_pkg, poi_mul and assert_macros.svh.
//
// Usage:
//   cmd (valid/ready) takes one control tick: forward speed, side speed, yaw rate.
//   pose (valid/ready) gives one result per tick: x, y and heading after the tick.
//   cfg (valid/ready, index + data) writes tick_period (0) and integrate_enable (1);
//   cfg_ready is always high, other indexes are dropped.
// Sequence:
//   Integrating: after the cmd transfer the tick runs the iterative CORDIC, then
//   the shared 33x18 multiplier steps through the products, then rounding and the
//   pose update. pose_valid rises and cmd_ready returns at the same edge.
//   Holding (integrate_enable = 0): the tick goes straight to the output load;
//   in both modes cmd_ready stays low until that load.
// A finished pose sits in the output register; while it waits, the next tick can
// be taken and worked on. If the receiver stalls, the block parks before the output
// load and holds cmd_ready low until the register frees up.
// Reset: pose state cleared to zero, tick_period = 1311, integration disabled.
`include "assert_macros.svh"

module planar_odometry_integrator_top
    import poi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  cmd_t                  cmd,

    output logic                  pose_valid,
    input  logic                  pose_ready,
    output pose_t                 pose,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PROD_W = MUL_A_W + MUL_B_W;

    poi_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg;

    // config
    logic [PER_W-1:0] period_reg;
    logic             enable_reg;

    // pose state
    logic signed [POS_W-1:0] acc_x_reg;
    logic signed [POS_W-1:0] acc_y_reg;
    logic [ANG_W-1:0]        acc_heading_reg;

    // tick operands
    logic signed [SPD_W:0] v_reg;
    logic signed [SPD_W:0] w_reg;
    logic signed [SPD_W:0] yaw_reg;

    // CORDIC
    logic                    flip_reg;
    logic signed [ANG_W-1:0] x_reg;
    logic signed [ANG_W-1:0] y_reg;
    logic signed [ANG_W-1:0] z_reg;
    logic signed [ANG_W-1:0] xs;
    logic signed [ANG_W-1:0] ys;
    logic [ANG_W-1:0]        at;

    // products
    logic signed [49:0] dx_reg;
    logic signed [49:0] dy_reg;
    logic [49:0]        dx_abs;
    logic [49:0]        dy_abs;
    logic [PROD_W-1:0]  prod_abs;
    logic               xneg_reg;
    logic               yneg_reg;
    logic               hneg_reg;
    logic [48:0]        xmag_reg;
    logic [48:0]        ymag_reg;
    logic [30:0]        hmag_reg;
    logic [63:0]        px_reg;
    logic [63:0]        py_reg;
    logic [63:0]        ph_reg;
    logic [63:0]        rx_sum;
    logic [63:0]        ry_sum;
    logic [63:0]        rh_sum;
    logic signed [22:0] dlt_x_reg;
    logic signed [22:0] dlt_y_reg;
    logic [ANG_W-1:0]   dh_reg;

    // shared multiplier
    logic                      mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    // output register
    pose_t out_reg;
    logic  out_valid_reg;
    logic  out_load;

    logic cmd_xfer;

    function automatic logic signed [POS_W-1:0] sat_add(
        input logic signed [POS_W-1:0] acc,
        input logic signed [22:0]      d
    );
        logic signed [POS_W:0] s;
        logic signed [POS_W-1:0] r;
        s = {acc[POS_W-1], acc} + {{(POS_W-22){d[22]}}, d};
        if (s[POS_W:POS_W-1] == 2'b01)
        begin
            r = {1'b0, {(POS_W-1){1'b1}}};
        end
        else if (s[POS_W:POS_W-1] == 2'b10)
        begin
            r = {1'b1, {(POS_W-1){1'b0}}};
        end
        else
        begin
            r = s[POS_W-1:0];
        end
        return r;
    endfunction

    poi_mul #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign cmd_ready  = (state_reg == ST_IDLE);
    assign cmd_xfer   = cmd_valid && cmd_ready;
    assign cfg_ready  = 1'b1;
    assign pose_valid = out_valid_reg;
    assign pose       = out_reg;

    // CORDIC step; >>> on signed gives the floor shift
    assign xs = x_reg >>> cnt_reg;
    assign ys = y_reg >>> cnt_reg;
    assign at = atan_bam(cnt_reg);

    assign dx_abs   = dx_reg[49] ? 50'(-dx_reg) : 50'(dx_reg);
    assign dy_abs   = dy_reg[49] ? 50'(-dy_reg) : 50'(dy_reg);
    assign prod_abs = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);

    // rounding of magnitudes, half away from zero
    assign rx_sum = px_reg + (64'd1 << 41);
    assign ry_sum = py_reg + (64'd1 << 41);
    assign rh_sum = ph_reg + (64'd1 << 29);

    always_comb
    begin
        state_next = state_reg;
        mul_en     = 1'b1;
        mul_a      = '0;
        mul_b      = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                mul_en = 1'b0;
                if (cmd_xfer)
                begin
                    state_next = enable_reg ? ST_ROT : ST_OUT;
                end
            end
            ST_ROT:
            begin
                mul_en = 1'b0;
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                mul_en     = 1'b0;
                state_next = ST_M0;
            end
            ST_M0:
            begin
                mul_a      = MUL_A_W'(x_reg);
                mul_b      = MUL_B_W'(v_reg);
                state_next = ST_M1;
            end
            ST_M1:
            begin
                mul_a      = MUL_A_W'(y_reg);
                mul_b      = MUL_B_W'(w_reg);
                state_next = ST_M2;
            end
            ST_M2:
            begin
                mul_a      = MUL_A_W'(y_reg);
                mul_b      = MUL_B_W'(v_reg);
                state_next = ST_M3;
            end
            ST_M3:
            begin
                mul_a      = MUL_A_W'(x_reg);
                mul_b      = MUL_B_W'(w_reg);
                state_next = ST_M4;
            end
            ST_M4:
            begin
                mul_a      = MUL_A_W'(yaw_reg);
                mul_b      = $signed({2'b00, period_reg});
                state_next = ST_M5;
            end
            ST_M5:
            begin
                mul_en     = 1'b0;
                state_next = ST_M6;
            end
            ST_M6:
            begin
                mul_a      = $signed({9'b0, xmag_reg[23:0]});
                mul_b      = $signed({2'b00, period_reg});
                state_next = ST_M7;
            end
            ST_M7:
            begin
                mul_a      = $signed({8'b0, xmag_reg[48:24]});
                mul_b      = $signed({2'b00, period_reg});
                state_next = ST_M8;
            end
            ST_M8:
            begin
                mul_a      = $signed({9'b0, ymag_reg[23:0]});
                mul_b      = $signed({2'b00, period_reg});
                state_next = ST_M9;
            end
            ST_M9:
            begin
                mul_a      = $signed({8'b0, ymag_reg[48:24]});
                mul_b      = $signed({2'b00, period_reg});
                state_next = ST_M10;
            end
            ST_M10:
            begin
                mul_a      = $signed({2'b00, hmag_reg});
                mul_b      = $signed({2'b00, RAD2BAM_LO});
                state_next = ST_M11;
            end
            ST_M11:
            begin
                mul_a      = $signed({2'b00, hmag_reg});
                mul_b      = $signed({2'b00, RAD2BAM_HI});
                state_next = ST_M12;
            end
            ST_M12:
            begin
                mul_en     = 1'b0;
                state_next = ST_RND;
            end
            ST_RND:
            begin
                mul_en     = 1'b0;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                mul_en     = 1'b0;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                mul_en = 1'b0;
                if (!out_valid_reg || pose_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                mul_en     = 1'b0;
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control and pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg         <= '0;
            period_reg      <= TICK_PERIOD_RST;
            enable_reg      <= 1'b0;
            acc_x_reg       <= '0;
            acc_y_reg       <= '0;
            acc_heading_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_TICK_PERIOD)
                begin
                    period_reg <= cfg_data[PER_W-1:0];
                end
                else if (cfg_index == CFG_INTEGRATE_EN)
                begin
                    enable_reg <= cfg_data[0];
                end
            end

            if (state_reg == ST_IDLE)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == ST_ROT)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            if (state_reg == ST_UPD)
            begin
                acc_x_reg       <= sat_add(acc_x_reg, dlt_x_reg);
                acc_y_reg       <= sat_add(acc_y_reg, dlt_y_reg);
                acc_heading_reg <= acc_heading_reg + dh_reg;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pose_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_xfer)
                begin
                    v_reg    <= (SPD_W+1)'(cmd.fwd_speed);
                    w_reg    <= -(SPD_W+1)'(cmd.side_speed);
                    yaw_reg  <= -(SPD_W+1)'(cmd.turn_rate);
                    // headings in [pi/2, 3pi/2) are turned by pi and the result negated
                    flip_reg <= acc_heading_reg[31] ^ acc_heading_reg[30];
                    x_reg    <= $signed(CORDIC_INV_GAIN);
                    y_reg    <= '0;
                    z_reg    <= $signed({acc_heading_reg[30], acc_heading_reg[30:0]});
                end
            end
            ST_ROT:
            begin
                if (!z_reg[ANG_W-1])
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - $signed(at);
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + $signed(at);
                end
            end
            ST_FIX:
            begin
                if (flip_reg)
                begin
                    x_reg <= -x_reg;
                    y_reg <= -y_reg;
                end
            end
            ST_M1:
            begin
                dx_reg <= prod[49:0];
            end
            ST_M2:
            begin
                dx_reg <= dx_reg - prod[49:0];
            end
            ST_M3:
            begin
                dy_reg <= prod[49:0];
            end
            ST_M4:
            begin
                dy_reg <= dy_reg + prod[49:0];
            end
            ST_M5:
            begin
                hneg_reg <= prod[PROD_W-1];
                hmag_reg <= prod_abs[30:0];
                xneg_reg <= dx_reg[49];
                xmag_reg <= dx_abs[48:0];
                yneg_reg <= dy_reg[49];
                ymag_reg <= dy_abs[48:0];
            end
            ST_M7:
            begin
                px_reg <= {{(64-PROD_W){1'b0}}, prod};
            end
            ST_M8:
            begin
                px_reg <= px_reg + {prod[39:0], 24'b0};
            end
            ST_M9:
            begin
                py_reg <= {{(64-PROD_W){1'b0}}, prod};
            end
            ST_M10:
            begin
                py_reg <= py_reg + {prod[39:0], 24'b0};
            end
            ST_M11:
            begin
                ph_reg <= {{(64-PROD_W){1'b0}}, prod};
            end
            ST_M12:
            begin
                ph_reg <= ph_reg + {prod[47:0], 16'b0};
            end
            ST_RND:
            begin
                dlt_x_reg <= xneg_reg ? -$signed({1'b0, rx_sum[63:42]})
                                      : $signed({1'b0, rx_sum[63:42]});
                dlt_y_reg <= yneg_reg ? -$signed({1'b0, ry_sum[63:42]})
                                      : $signed({1'b0, ry_sum[63:42]});
                // heading wraps, so only the low 32 bits of the magnitude matter
                dh_reg    <= hneg_reg ? -rh_sum[61:30] : rh_sum[61:30];
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_reg.pose_x       <= acc_x_reg;
                    out_reg.pose_y       <= acc_y_reg;
                    out_reg.pose_heading <= acc_heading_reg[ANG_W-1:ANG_W-HDG_W];
                end
            end
            default:
            begin
            end
        endcase
    end

    `POI_ASSERT_NEXT(a_acc_only_in_upd, state_reg != ST_UPD,
        $stable(acc_x_reg) && $stable(acc_y_reg) && $stable(acc_heading_reg),
        "pose state changed outside the update step")

    `POI_ASSERT_NEXT(a_rot_starts_clean, cmd_xfer && enable_reg,
        (state_reg == ST_ROT) && (cnt_reg == '0),
        "rotation did not start at step zero after an integrating transfer")

    `POI_ASSERT_IMPL(a_cordic_converged, state_reg == ST_FIX,
        (z_reg < 32'sd64) && (z_reg > -32'sd64),
        "CORDIC residual angle did not converge")

    `POI_ASSERT_IMPL(a_pose_from_out, $rose(pose_valid),
        $past(state_reg) == ST_OUT,
        "pose_valid rose without an output load")

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for planar_odometry_integrator_top: directed and random ticks,
// with the expected pose worked out by a bit-exact CORDIC pose tracker in this file.
// Depends on poi_pkg and the planar_odometry_integrator_top RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import poi_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 60;
    localparam int PHASE_ITEMS    = 86;
    localparam int PHASES         = 6;
    localparam int SAT_TICKS      = 20;
    localparam int ROT_STEPS      = 28;
    localparam int IDLE_PCT       = 23;

    localparam logic [POS_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0] POS_MIN = 32'h8000_0000;
    // 8/pi in Q2.30: radians to 32-bit binary angle
    localparam longint RAD_TO_BAM = 64'd2734261102;

    // arctan(2^-i) as 32-bit binary angles
    localparam logic [ANG_W-1:0] ATAN_TBL [ROT_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005
    };

    class pose_tracker;
        logic [PER_W-1:0] period;
        bit               integrating;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [ANG_W-1:0] heading;
        pose_t            poses_due[$];
        int               fails;

        function new();
            period      = TICK_PERIOD_RST;
            integrating = 1'b0;
            pos_x       = '0;
            pos_y       = '0;
            heading     = '0;
            fails       = 0;
        endfunction

        function int pending();
            return poses_due.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_TICK_PERIOD)
                period = data[PER_W-1:0];
            else if (idx == CFG_INTEGRATE_EN)
                integrating = data[0];
        endfunction

        // cos/sin of the heading in Q1.30; headings in the back half are turned by pi
        function void rotate(logic [ANG_W-1:0] a, output longint c, output longint s);
            logic [ANG_W-1:0] shifted;
            logic [ANG_W-1:0] r;
            bit               flip;
            longint           x;
            longint           y;
            longint           z;
            longint           xs;
            longint           ys;
            shifted = a + 32'h4000_0000;
            flip    = shifted[ANG_W-1];
            r       = flip ? a + 32'h8000_0000 : a;
            z       = longint'($signed(r));
            x       = longint'(CORDIC_INV_GAIN);
            y       = 0;
            for (int i = 0; i < ROT_STEPS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0)
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - longint'(ATAN_TBL[i]);
                end
                else
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + longint'(ATAN_TBL[i]);
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        // round magnitude half away from zero
        function longint round_shift(longint v, int n);
            longint unsigned m;
            m = (v < 0) ? -v : v;
            m = (m + (64'd1 << (n - 1))) >> n;
            return (v < 0) ? -longint'(m) : longint'(m);
        endfunction

        function logic [POS_W-1:0] sat_add(logic [POS_W-1:0] acc, longint d);
            longint sum;
            sum = longint'($signed(acc)) + d;
            if (sum > longint'($signed(POS_MAX)))
                sum = longint'($signed(POS_MAX));
            if (sum < longint'($signed(POS_MIN)))
                sum = longint'($signed(POS_MIN));
            return sum[POS_W-1:0];
        endfunction

        function void note_cmd(cmd_t c);
            longint v;
            longint w;
            longint yaw;
            longint per;
            longint cs;
            longint sn;
            longint dx;
            longint dy;
            longint dh;
            pose_t  p;
            if (integrating)
            begin
                v   = longint'($signed(c.fwd_speed));
                w   = -longint'($signed(c.side_speed));
                yaw = -longint'($signed(c.turn_rate));
                per = longint'(period);
                rotate(heading, cs, sn);
                dx  = v * cs - w * sn;
                dy  = v * sn + w * cs;
                pos_x = sat_add(pos_x, round_shift(dx * per, 42));
                pos_y = sat_add(pos_y, round_shift(dy * per, 42));
                dh  = round_shift(yaw * per * RAD_TO_BAM, 30);
                heading = heading + dh[ANG_W-1:0];
            end
            p.pose_x       = pos_x;
            p.pose_y       = pos_y;
            p.pose_heading = heading[ANG_W-1 -: HDG_W];
            poses_due = {poses_due, p};
        endfunction

        function void check_pose(pose_t got);
            pose_t want;
            if (poses_due.size() == 0)
            begin
                $error("pose transfer with no pose expected: x %0d y %0d heading %0d",
                       got.pose_x, got.pose_y, got.pose_heading);
                fails++;
                return;
            end
            want = poses_due.pop_front();
            if (got.pose_x !== want.pose_x)
            begin
                $error("pose_x: expected %0d, got %0d", want.pose_x, got.pose_x);
                fails++;
            end
            if (got.pose_y !== want.pose_y)
            begin
                $error("pose_y: expected %0d, got %0d", want.pose_y, got.pose_y);
                fails++;
            end
            if (got.pose_heading !== want.pose_heading)
            begin
                $error("pose_heading: expected %0d, got %0d",
                       want.pose_heading, got.pose_heading);
                fails++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cmd_valid;
    logic                  cmd_ready;
    cmd_t                  cmd;
    logic                  pose_valid;
    logic                  pose_ready;
    pose_t                 pose;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pose_tracker tracker;
    bit          calm;
    int          stall_requests;
    int          stalls_served;
    int          hold_left;
    int          quiet_cycles;

    planar_odometry_integrator_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .pose_valid (pose_valid),
        .pose_ready (pose_ready),
        .pose       (pose),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // pose receiver: random stalls, calm stretches, and long hold-offs on request
    initial
    begin
        pose_ready    = 1'b0;
        stalls_served = 0;
        hold_left     = 0;
        forever
        begin
            @(negedge clk);
            if (stall_requests != stalls_served)
            begin
                stalls_served++;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                pose_ready = 1'b0;
                hold_left--;
            end
            else if (calm)
                pose_ready = 1'b1;
            else
                pose_ready = ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pose_valid && pose_ready)
                tracker.check_pose(pose);
            if (cmd_valid && cmd_ready)
                tracker.note_cmd(cmd);
            if (cfg_valid && cfg_ready)
                tracker.write_reg(cfg_index, cfg_data);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && cmd_ready) || (pose_valid && pose_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic cmd_t make_cmd(logic [SPD_W-1:0] f, logic [SPD_W-1:0] s,
                                      logic [SPD_W-1:0] t);
        cmd_t c;
        c.fwd_speed  = f;
        c.side_speed = s;
        c.turn_rate  = t;
        return c;
    endfunction

    // mostly uniform, sometimes a corner value
    function automatic logic [SPD_W-1:0] rand_speed();
        if ($urandom_range(7) == 0)
            case ($urandom_range(3))
                0:       return 16'h8000;
                1:       return 16'h7FFF;
                2:       return 16'h0000;
                default: return 16'hFFFF;
            endcase
        return SPD_W'($urandom);
    endfunction

    task automatic send_cmd(input cmd_t c);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            gap = $urandom_range(50, 1);
            cmd_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid = 1'b1;
        cmd       = c;
        do @(posedge clk); while (!cmd_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // stop offering ticks and wait for every pose to come back
    task automatic wait_drained();
        @(negedge clk);
        cmd_valid = 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_enable(input bit en);
        logic [CFG_DATA_W-1:0] data;
        data    = CFG_DATA_W'($urandom);
        data[0] = en;
        write_reg(CFG_INTEGRATE_EN, data);
    endtask

    initial
    begin
        cmd_t                  sat_cmd;
        logic [CFG_DATA_W-1:0] per;
        tracker        = new();
        calm           = 1'b0;
        stall_requests = 0;
        quiet_cycles   = 0;
        rst_n          = 1'b0;
        cmd_valid      = 1'b0;
        cmd            = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // integration off out of reset: pose holds at zero
        send_cmd(make_cmd(16'h8000, 16'h8000, 16'h8000));
        send_cmd(make_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF));
        wait_drained();

        // heading zero, full speed ahead and to the side
        write_reg(CFG_TICK_PERIOD, 16'hFFFF);
        set_enable(1'b1);
        sat_cmd = make_cmd(16'h7FFF, 16'h7FFF, 16'h0000);
        repeat (SAT_TICKS) send_cmd(sat_cmd);

        send_cmd(make_cmd(16'h0000, 16'h0000, 16'h0000));
        send_cmd(make_cmd(16'h8000, 16'h0000, 16'h0000));
        send_cmd(make_cmd(16'h7FFF, 16'h0000, 16'h0000));
        send_cmd(make_cmd(16'h0000, 16'h8000, 16'h0000));
        send_cmd(make_cmd(16'h0000, 16'h7FFF, 16'h0000));
        send_cmd(make_cmd(16'h0000, 16'h0000, 16'h8000));
        send_cmd(make_cmd(16'h0000, 16'h0000, 16'h7FFF));
        send_cmd(make_cmd(16'h8000, 16'h8000, 16'h8000));
        send_cmd(make_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF));
        wait_drained();

        // writes to unused indexes must change nothing
        write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, CFG_INTEGRATE_EN + 1)),
                  CFG_DATA_W'($urandom));
        send_cmd(make_cmd(16'h4000, 16'hC000, 16'h2000));
        wait_drained();

        // zero period: pose holds even with integration on
        write_reg(CFG_TICK_PERIOD, 16'h0000);
        send_cmd(make_cmd(16'h7FFF, 16'h8000, 16'h8000));
        send_cmd(make_cmd(16'h8000, 16'h7FFF, 16'h7FFF));
        wait_drained();

        write_reg(CFG_TICK_PERIOD, 16'h0001);
        send_cmd(make_cmd(16'h8000, 16'h8000, 16'h8000));
        send_cmd(make_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF));
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       per = 16'hFFFF;
                2:       per = 16'h0000;
                3:       per = 16'h0001;
                4:       per = TICK_PERIOD_RST;
                default: per = CFG_DATA_W'($urandom);
            endcase
            write_reg(CFG_TICK_PERIOD, per);
            set_enable(ph != 4);
            calm = (ph == 1);
            // receiver holds off while ticks keep coming, so the block backs up
            if (ph == 3)
                stall_requests++;
            repeat (PHASE_ITEMS) send_cmd(make_cmd(rand_speed(), rand_speed(), rand_speed()));
            wait_drained();
            calm = 1'b0;
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.fails == 0 && tracker.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
